>>> hdl/xsr_pkg.sv
// shared types and constants for the xoshiro256** bounded generator
`default_nettype none
package xsr_pkg;

    // splitmix64 and golden-ratio constants
    localparam logic [63:0] GOLDEN_GAMMA = 64'h9e3779b97f4a7c15;
    localparam logic [63:0] MIX_MUL_A    = 64'hbf58476d1ce4e5b9;
    localparam logic [63:0] MIX_MUL_B    = 64'h94d049bb133111eb;

    // action codes
    localparam logic [1:0] ACT_RAW     = 2'd0;
    localparam logic [1:0] ACT_BOUNDED = 2'd1;
    localparam logic [1:0] ACT_FRAC    = 2'd2;
    localparam logic [1:0] ACT_UNUSED  = 2'd3;

    typedef enum logic [3:0] {
        ST_SEED_ACC,
        ST_SEED_LA,
        ST_SEED_WA,
        ST_SEED_LB,
        ST_SEED_WB,
        ST_SEED_WR,
        ST_SEED_FIX,
        ST_IDLE,
        ST_EXEC,
        ST_WAIT_M,
        ST_CHECK,
        ST_WAIT_D,
        ST_RESULT
    } state_t;

    // multiplier operand selection
    typedef enum logic [1:0] {
        MSEL_MIXA,
        MSEL_MIXB,
        MSEL_BOUND
    } msel_t;

    // result selection
    typedef enum logic [1:0] {
        RSEL_RAW,
        RSEL_FRAC,
        RSEL_ZERO,
        RSEL_HI
    } rsel_t;

    typedef struct packed {
        logic  acc_step;
        logic  mul_load;
        msel_t msel;
        logic  word_write;
        logic  golden_fix;
        logic  draw_step;
        logic  res_load;
        rsel_t rsel;
        logic  div_load;
        logic  item_load;
        logic  out_load;
    } cmd_t;

    typedef struct packed {
        logic       mul_done;
        logic       div_done;
        logic       mul_busy;
        logic       div_busy;
        logic       last_word;
        logic [1:0] action;
        logic       bound_zero;
        logic       lo_below_bound;
        logic       thr_valid;
        logic       lo_below_thr;
        logic       out_free;
    } status_t;

endpackage
`default_nettype wire

>>> hdl/xsr_ctrl.sv
// controller state machine for the xoshiro256** bounded generator
`default_nettype none
module xsr_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             seed_we,
    input  wire logic             in_valid,
    output logic                  in_stall,
    input  wire xsr_pkg::status_t st,
    output xsr_pkg::cmd_t         cmd
);

    xsr_pkg::state_t state_reg;
    xsr_pkg::state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= xsr_pkg::ST_SEED_ACC;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            xsr_pkg::ST_SEED_ACC: state_next = xsr_pkg::ST_SEED_LA;
            xsr_pkg::ST_SEED_LA:  state_next = xsr_pkg::ST_SEED_WA;
            xsr_pkg::ST_SEED_WA:
            begin
                if (st.mul_done)
                begin
                    state_next = xsr_pkg::ST_SEED_LB;
                end
            end
            xsr_pkg::ST_SEED_LB:  state_next = xsr_pkg::ST_SEED_WB;
            xsr_pkg::ST_SEED_WB:
            begin
                if (st.mul_done)
                begin
                    state_next = xsr_pkg::ST_SEED_WR;
                end
            end
            xsr_pkg::ST_SEED_WR:
            begin
                state_next = st.last_word ? xsr_pkg::ST_SEED_FIX : xsr_pkg::ST_SEED_ACC;
            end
            xsr_pkg::ST_SEED_FIX: state_next = xsr_pkg::ST_IDLE;
            xsr_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = xsr_pkg::ST_EXEC;
                end
            end
            xsr_pkg::ST_EXEC:
            begin
                if (st.action == xsr_pkg::ACT_BOUNDED && !st.bound_zero)
                begin
                    state_next = xsr_pkg::ST_WAIT_M;
                end
                else
                begin
                    state_next = xsr_pkg::ST_RESULT;
                end
            end
            xsr_pkg::ST_WAIT_M:
            begin
                if (st.mul_done)
                begin
                    state_next = xsr_pkg::ST_CHECK;
                end
            end
            xsr_pkg::ST_CHECK:
            begin
                if (!st.lo_below_bound)
                begin
                    state_next = xsr_pkg::ST_RESULT;
                end
                else if (!st.thr_valid)
                begin
                    state_next = xsr_pkg::ST_WAIT_D;
                end
                else if (st.lo_below_thr)
                begin
                    state_next = xsr_pkg::ST_WAIT_M;
                end
                else
                begin
                    state_next = xsr_pkg::ST_RESULT;
                end
            end
            xsr_pkg::ST_WAIT_D:
            begin
                if (st.div_done)
                begin
                    state_next = xsr_pkg::ST_CHECK;
                end
            end
            xsr_pkg::ST_RESULT:
            begin
                if (st.out_free)
                begin
                    state_next = xsr_pkg::ST_IDLE;
                end
            end
            default: state_next = xsr_pkg::ST_SEED_ACC;
        endcase
        // a seed write restarts the expansion
        if (seed_we)
        begin
            state_next = xsr_pkg::ST_SEED_ACC;
        end
    end

    // command outputs
    always_comb
    begin
        cmd      = '0;
        cmd.msel = xsr_pkg::MSEL_MIXA;
        cmd.rsel = xsr_pkg::RSEL_ZERO;
        in_stall = 1'b1;
        case (state_reg)
            xsr_pkg::ST_SEED_ACC: cmd.acc_step = 1'b1;
            xsr_pkg::ST_SEED_LA:
            begin
                cmd.mul_load = 1'b1;
                cmd.msel     = xsr_pkg::MSEL_MIXA;
            end
            xsr_pkg::ST_SEED_LB:
            begin
                cmd.mul_load = 1'b1;
                cmd.msel     = xsr_pkg::MSEL_MIXB;
            end
            xsr_pkg::ST_SEED_WR:  cmd.word_write = 1'b1;
            xsr_pkg::ST_SEED_FIX: cmd.golden_fix = 1'b1;
            xsr_pkg::ST_IDLE:
            begin
                in_stall      = 1'b0;
                cmd.item_load = in_valid;
            end
            xsr_pkg::ST_EXEC:
            begin
                case (st.action)
                    xsr_pkg::ACT_RAW:
                    begin
                        cmd.draw_step = 1'b1;
                        cmd.res_load  = 1'b1;
                        cmd.rsel      = xsr_pkg::RSEL_RAW;
                    end
                    xsr_pkg::ACT_FRAC:
                    begin
                        cmd.draw_step = 1'b1;
                        cmd.res_load  = 1'b1;
                        cmd.rsel      = xsr_pkg::RSEL_FRAC;
                    end
                    xsr_pkg::ACT_BOUNDED:
                    begin
                        if (st.bound_zero)
                        begin
                            cmd.res_load = 1'b1;
                        end
                        else
                        begin
                            cmd.draw_step = 1'b1;
                            cmd.mul_load  = 1'b1;
                            cmd.msel      = xsr_pkg::MSEL_BOUND;
                        end
                    end
                    default: cmd.res_load = 1'b1;
                endcase
            end
            xsr_pkg::ST_CHECK:
            begin
                if (!st.lo_below_bound)
                begin
                    cmd.res_load = 1'b1;
                    cmd.rsel     = xsr_pkg::RSEL_HI;
                end
                else if (!st.thr_valid)
                begin
                    cmd.div_load = 1'b1;
                end
                else if (st.lo_below_thr)
                begin
                    cmd.draw_step = 1'b1;
                    cmd.mul_load  = 1'b1;
                    cmd.msel      = xsr_pkg::MSEL_BOUND;
                end
                else
                begin
                    cmd.res_load = 1'b1;
                    cmd.rsel     = xsr_pkg::RSEL_HI;
                end
            end
            xsr_pkg::ST_RESULT: cmd.out_load = st.out_free;
            default: cmd = '0;
        endcase
    end

endmodule
`default_nettype wire

>>> hdl/xsr_dp.sv
// datapath: generator state, splitmix expansion, multiplier, divider, output register
`default_nettype none
module xsr_dp (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          seed_we,
    input  wire logic [63:0]   seed_data,
    input  wire logic [1:0]    action,
    input  wire logic [63:0]   bound,
    output logic               out_valid,
    input  wire logic          out_stall,
    output logic [63:0]        value,
    input  wire xsr_pkg::cmd_t cmd,
    output xsr_pkg::status_t   st
);

    logic [63:0]  w_reg [4];
    logic [63:0]  acc_reg;
    logic [1:0]   idx_reg;
    logic [1:0]   action_reg;
    logic [63:0]  bound_reg;
    logic [63:0]  mul_a_reg;
    logic [63:0]  mul_b_reg;
    logic [127:0] prod_reg;
    logic [1:0]   mcnt_reg;
    logic         mbusy_reg;
    logic [63:0]  num_reg;
    logic [63:0]  rem_reg;
    logic [5:0]   dcnt_reg;
    logic         dbusy_reg;
    logic         thr_valid_reg;
    logic [63:0]  res_reg;
    logic [63:0]  value_reg;
    logic         out_valid_reg;

    // xoshiro256** output and state update
    logic [63:0] w1x5, rot7, draw_out;
    logic [63:0] n0, n1, n2, n3;
    always_comb
    begin
        w1x5     = w_reg[1] + {w_reg[1][61:0], 2'b00};
        rot7     = {w1x5[56:0], w1x5[63:57]};
        draw_out = rot7 + {rot7[60:0], 3'b000};
        n2       = w_reg[2] ^ w_reg[0];
        n3       = w_reg[3] ^ w_reg[1];
        n1       = w_reg[1] ^ n2;
        n0       = w_reg[0] ^ n3;
    end

    // splitmix finishing terms
    logic [63:0] mix_a_in, mix_b_in, mix_out;
    always_comb
    begin
        mix_a_in = acc_reg ^ (acc_reg >> 30);
        mix_b_in = prod_reg[63:0] ^ (prod_reg[63:0] >> 27);
        mix_out  = prod_reg[63:0] ^ (prod_reg[63:0] >> 31);
    end

    // one 32x32 partial product per cycle
    logic [31:0]  pa, pb;
    logic [63:0]  pp;
    logic [127:0] pp_shift;
    always_comb
    begin
        pa = mcnt_reg[1] ? mul_a_reg[63:32] : mul_a_reg[31:0];
        pb = mcnt_reg[0] ? mul_b_reg[63:32] : mul_b_reg[31:0];
        pp = pa * pb;
        case ({1'b0, mcnt_reg[1]} + {1'b0, mcnt_reg[0]})
            2'd0:    pp_shift = {64'd0, pp};
            2'd1:    pp_shift = {32'd0, pp, 32'd0};
            default: pp_shift = {pp, 64'd0};
        endcase
    end

    // one restoring division bit per cycle
    logic [64:0] rem_sh;
    logic        rem_ge;
    always_comb
    begin
        rem_sh = {rem_reg, num_reg[63]};
        rem_ge = rem_sh >= {1'b0, bound_reg};
    end

    // generator words and seed expansion
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
            idx_reg <= '0;
        end
        else if (seed_we)
        begin
            acc_reg <= seed_data;
            idx_reg <= '0;
        end
        else
        begin
            if (cmd.acc_step)
            begin
                acc_reg <= acc_reg + xsr_pkg::GOLDEN_GAMMA;
            end
            if (cmd.word_write)
            begin
                idx_reg <= idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.word_write)
        begin
            w_reg[idx_reg] <= mix_out;
        end
        else if (cmd.golden_fix)
        begin
            if ((w_reg[0] | w_reg[1] | w_reg[2] | w_reg[3]) == 64'd0)
            begin
                w_reg[0] <= xsr_pkg::GOLDEN_GAMMA;
            end
        end
        else if (cmd.draw_step)
        begin
            w_reg[0] <= n0;
            w_reg[1] <= n1;
            w_reg[2] <= n2 ^ {w_reg[1][46:0], 17'd0};
            w_reg[3] <= {n3[18:0], n3[63:19]};
        end
    end

    // item capture
    always_ff @(posedge clk)
    begin
        if (cmd.item_load)
        begin
            action_reg <= action;
            bound_reg  <= bound;
        end
    end

    // multiplier control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mbusy_reg <= 1'b0;
            mcnt_reg  <= '0;
        end
        else if (cmd.mul_load)
        begin
            mbusy_reg <= 1'b1;
            mcnt_reg  <= '0;
        end
        else if (mbusy_reg)
        begin
            mcnt_reg <= mcnt_reg + 2'd1;
            if (mcnt_reg == 2'd3)
            begin
                mbusy_reg <= 1'b0;
            end
        end
    end

    // multiplier operands and accumulator
    always_ff @(posedge clk)
    begin
        if (cmd.mul_load)
        begin
            prod_reg <= '0;
            case (cmd.msel)
                xsr_pkg::MSEL_MIXA:
                begin
                    mul_a_reg <= mix_a_in;
                    mul_b_reg <= xsr_pkg::MIX_MUL_A;
                end
                xsr_pkg::MSEL_MIXB:
                begin
                    mul_a_reg <= mix_b_in;
                    mul_b_reg <= xsr_pkg::MIX_MUL_B;
                end
                default:
                begin
                    mul_a_reg <= draw_out;
                    mul_b_reg <= bound_reg;
                end
            endcase
        end
        else if (mbusy_reg)
        begin
            prod_reg <= prod_reg + pp_shift;
        end
    end

    // divider control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dbusy_reg     <= 1'b0;
            dcnt_reg      <= '0;
            thr_valid_reg <= 1'b0;
        end
        else if (cmd.item_load)
        begin
            thr_valid_reg <= 1'b0;
        end
        else if (cmd.div_load)
        begin
            dbusy_reg <= 1'b1;
            dcnt_reg  <= '0;
        end
        else if (dbusy_reg)
        begin
            dcnt_reg <= dcnt_reg + 6'd1;
            if (dcnt_reg == 6'd63)
            begin
                dbusy_reg     <= 1'b0;
                thr_valid_reg <= 1'b1;
            end
        end
    end

    // (2^64 - bound) mod bound
    always_ff @(posedge clk)
    begin
        if (cmd.div_load)
        begin
            num_reg <= 64'd0 - bound_reg;
            rem_reg <= '0;
        end
        else if (dbusy_reg)
        begin
            num_reg <= {num_reg[62:0], 1'b0};
            rem_reg <= rem_ge ? 64'(rem_sh - {1'b0, bound_reg}) : rem_sh[63:0];
        end
    end

    // result staging
    always_ff @(posedge clk)
    begin
        if (cmd.res_load)
        begin
            case (cmd.rsel)
                xsr_pkg::RSEL_RAW:  res_reg <= draw_out;
                xsr_pkg::RSEL_FRAC: res_reg <= {11'd0, draw_out[63:11]};
                xsr_pkg::RSEL_HI:   res_reg <= prod_reg[127:64];
                default:            res_reg <= '0;
            endcase
        end
    end

    // output beat register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            value_reg <= res_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign value     = value_reg;

    // status to the controller
    always_comb
    begin
        st.mul_done       = mbusy_reg && (mcnt_reg == 2'd3);
        st.div_done       = dbusy_reg && (dcnt_reg == 6'd63);
        st.mul_busy       = mbusy_reg;
        st.div_busy       = dbusy_reg;
        st.last_word      = (idx_reg == 2'd3);
        st.action         = action_reg;
        st.bound_zero     = (bound_reg == 64'd0);
        st.lo_below_bound = prod_reg[63:0] < bound_reg;
        st.thr_valid      = thr_valid_reg;
        st.lo_below_thr   = prod_reg[63:0] < rem_reg;
        st.out_free       = !out_valid_reg || !out_stall;
    end

endmodule
`default_nettype wire

>>> hdl/xoshiro256ss_bounded_rng.sv
// top level of the xoshiro256** generator with raw, fraction and bounded draws
// A request beat takes one item at a time. Raw draws, fractions, zero bounds and
// unused actions pass from the execute state to the result state, which waits for a
// free output register before raising out_valid. A bounded draw runs the 128-bit
// product through one 32x32 multiplier, one partial product at a time; when the low
// product word falls below the bound the rejection threshold comes from a
// one-bit-per-cycle divider, once per item, and the draw is repeated while the low
// word falls below that threshold. After reset and after each seed write the block
// expands the seed through four splitmix64 steps and holds in_stall high meanwhile.
// A finished result waits in the output register while the next item is accepted.
`default_nettype none
module xoshiro256ss_bounded_rng (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        seed_we,
    input  wire logic [63:0] seed_data,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  action,
    input  wire logic [63:0] bound,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [63:0]      value
);

    xsr_pkg::cmd_t    cmd;
    xsr_pkg::status_t st;

    // controller
    xsr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .seed_we  (seed_we),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .st       (st),
        .cmd      (cmd)
    );

    // datapath
    xsr_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .seed_we   (seed_we),
        .seed_data (seed_data),
        .action    (action),
        .bound     (bound),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .value     (value),
        .cmd       (cmd),
        .st        (st)
    );

    // checks that the multiplier and divider never run together
    assert property (@(posedge clk) disable iff (!rst_n) !(st.mul_busy && st.div_busy))
        else $error("multiplier and divider busy together");

    // an accepted beat blocks the next one
    assert property (@(posedge clk) disable iff (!rst_n) (in_valid && !in_stall) |=> in_stall)
        else $error("second beat accepted while busy");

    // a seed write holds off requests during expansion
    assert property (@(posedge clk) disable iff (!rst_n) seed_we |=> in_stall)
        else $error("request accepted during seed expansion");

endmodule
`default_nettype wire
